// ===== sv/rfb_pkg.sv =====
// Shared types and constants for the RGB565 to one-bit frame store core.
`timescale 1ns / 1ps
package rfb_pkg;

   localparam int CFG_WIDTH     = 9;
   localparam int CSR_INDEX_W   = 2;
   localparam int STORE_ADDR_W  = 13;
   localparam int INDEX_CALC_W  = 14;
   localparam int GRAY_SUM_W    = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIENTATION    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DARK_THRESHOLD = 2'd3;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_PIXEL = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [8:0] IMAGE_WIDTH_RESET    = 9'd250;
   localparam logic [8:0] IMAGE_HEIGHT_RESET   = 9'd122;
   localparam logic [7:0] DARK_THRESHOLD_RESET = 8'd128;

   localparam logic [GRAY_SUM_W-1:0] GRAY_RED_WEIGHT   = 15'd30;
   localparam logic [GRAY_SUM_W-1:0] GRAY_GREEN_WEIGHT = 15'd59;
   localparam logic [GRAY_SUM_W-1:0] GRAY_BLUE_WEIGHT  = 15'd11;
   localparam logic [GRAY_SUM_W-1:0] GRAY_DIVISOR      = 15'd100;

   localparam logic [7:0] WHITE_BYTE = 8'hFF;
   localparam logic [7:0] MSB_MASK   = 8'h80;
   localparam logic [2:0] BIT_SEL_MASK = 3'd7;

   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [STORE_ADDR_W-1:0] addr;
      logic [2:0]              bit_sel;
      logic                    set_bit;
      logic                    last;
   } cmd_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       last_byte;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_CLEAR = 2'b10
   } back_state_type;

endpackage

// ===== sv/rfb_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module rfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rfb_queue.sv =====
// Small first-in first-out queue built from registers.
`timescale 1ns / 1ps
module rfb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           head_data,
   output logic                       not_empty,
   output logic                       full,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign count     = count_ff;

endmodule

// ===== sv/rfb_front.sv =====
// Front end: configuration registers, raster counters, gray threshold and address mapping.
`timescale 1ns / 1ps
module rfb_front #(
   parameter int PANEL_WIDTH  = 250,
   parameter int PANEL_HEIGHT = 122,
   parameter int ROW_BYTES    = 16,
   parameter int STORE_BYTES  = 4000
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [rfb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rfb_pkg::CFG_WIDTH-1:0]      csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [4:0]                         req_red,
   input  logic [5:0]                         req_green,
   input  logic [4:0]                         req_blue,
   output logic                               cmd_push,
   output rfb_pkg::cmd_type                   cmd_data,
   input  logic                               cmd_full
);
   import rfb_pkg::*;

   localparam int AW = $clog2(STORE_BYTES);

   logic [8:0]    image_width_ff, image_height_ff;
   logic          orientation_ff;
   logic [7:0]    dark_threshold_ff;
   logic [7:0]    column_ff, column_in;
   logic [8:0]    row_ff, row_in;
   logic [AW-1:0] read_ptr_ff, read_ptr_in;

   logic                    accept;
   logic [GRAY_SUM_W-1:0]   gray_sum, dark_limit;
   logic                    is_dark;
   logic                    on_image;
   logic                    map_ok;
   logic [8:0]              mirror_x;
   logic [7:0]              px, py;
   logic [INDEX_CALC_W-1:0] byte_index;
   logic                    in_store;
   logic                    read_last;

   assign req_ready = !cmd_full;
   assign accept    = req_valid && req_ready;

   // gray = sum / 100 truncated, so gray < t exactly when sum < 100 * t.
   assign gray_sum = (GRAY_SUM_W'(req_red)   << 3) * GRAY_RED_WEIGHT
                   + (GRAY_SUM_W'(req_green) << 2) * GRAY_GREEN_WEIGHT
                   + (GRAY_SUM_W'(req_blue)  << 3) * GRAY_BLUE_WEIGHT;
   assign dark_limit = GRAY_SUM_W'(dark_threshold_ff) * GRAY_DIVISOR;
   assign is_dark    = gray_sum < dark_limit;

   assign on_image = ({1'b0, column_ff} < image_width_ff)
                  && ({1'b0, column_ff} < 9'(PANEL_WIDTH))
                  && (row_ff < image_height_ff)
                  && (row_ff < 9'(PANEL_HEIGHT));

   assign mirror_x = 9'(PANEL_HEIGHT - 1) - {1'b0, column_ff};

   always_comb begin
      if (!orientation_ff) begin
         px     = row_ff[7:0];
         py     = column_ff;
         map_ok = 1'b1;
      end else begin
         px     = mirror_x[7:0];
         py     = row_ff[7:0];
         map_ok = {1'b0, column_ff} < 9'(PANEL_HEIGHT);
      end
   end

   assign byte_index = INDEX_CALC_W'(py) * INDEX_CALC_W'(ROW_BYTES)
                     + INDEX_CALC_W'(px >> 3);
   assign in_store   = byte_index < INDEX_CALC_W'(STORE_BYTES);
   assign read_last  = (read_ptr_ff == AW'(STORE_BYTES - 1));

   always_comb begin
      cmd_push         = 1'b0;
      cmd_data.op      = OP_CLEAR;
      cmd_data.addr    = '0;
      cmd_data.bit_sel = px[2:0] & BIT_SEL_MASK;
      cmd_data.set_bit = !is_dark;
      cmd_data.last    = read_last;
      column_in        = column_ff;
      row_in           = row_ff;
      read_ptr_in      = read_ptr_ff;
      if (accept) begin
         case (req_action)
            ACT_START: begin
               cmd_push    = 1'b1;
               cmd_data.op = OP_CLEAR;
               column_in   = '0;
               row_in      = '0;
               read_ptr_in = '0;
            end
            ACT_PIXEL: begin
               cmd_push      = on_image && map_ok && in_store;
               cmd_data.op   = OP_WRITE;
               cmd_data.addr = byte_index[STORE_ADDR_W-1:0];
               if (({1'b0, column_ff} + 9'd1 >= image_width_ff) || (column_ff == '1)) begin
                  column_in = '0;
                  if (row_ff != '1) begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  column_in = column_ff + 1'b1;
               end
            end
            ACT_READ: begin
               cmd_push      = 1'b1;
               cmd_data.op   = OP_READ;
               cmd_data.addr = STORE_ADDR_W'(read_ptr_ff);
               read_ptr_in   = read_last ? '0 : read_ptr_ff + 1'b1;
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= IMAGE_WIDTH_RESET;
         image_height_ff   <= IMAGE_HEIGHT_RESET;
         orientation_ff    <= 1'b0;
         dark_threshold_ff <= DARK_THRESHOLD_RESET;
         column_ff         <= '0;
         row_ff            <= '0;
         read_ptr_ff       <= '0;
      end else begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         read_ptr_ff <= read_ptr_in;
         if (csr_write) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:    image_width_ff    <= csr_wdata;
               CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_wdata;
               CSR_ORIENTATION:    orientation_ff    <= csr_wdata[0];
               CSR_DARK_THRESHOLD: dark_threshold_ff <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// ===== sv/rfb_back.sv =====
// Back end: frame store, clearing sweep, bit read-modify-write and read-out queue.
`timescale 1ns / 1ps
module rfb_back #(
   parameter int STORE_BYTES = 4000
) (
   input  logic             clock,
   input  logic             reset,
   input  rfb_pkg::cmd_type cmd_head,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_packed_byte,
   output logic             rsp_last_byte
);
   import rfb_pkg::*;

   localparam int AW  = $clog2(STORE_BYTES);
   localparam int RCW = $clog2(RSP_QUEUE_DEPTH + 1);

   back_state_type state_ff, state_in;
   logic [AW-1:0]  clear_addr_ff, clear_addr_in;

   logic           stage_valid_ff;
   op_type         stage_op_ff;
   logic [AW-1:0]  stage_addr_ff;
   logic [2:0]     stage_bit_ff;
   logic           stage_set_ff;
   logic           stage_last_ff;

   logic           fwd_valid_ff;
   logic [AW-1:0]  fwd_addr_ff;
   logic [7:0]     fwd_data_ff;

   logic           ram_wr_en;
   logic [AW-1:0]  ram_wr_addr;
   logic [7:0]     ram_wr_data;
   logic [7:0]     ram_rd_data;

   logic [7:0]     cur_byte, bit_mask, merged_byte;
   logic           stage_write, stage_read;

   logic           rsp_push, rsp_pop, rsp_not_empty, rsp_full;
   logic [RCW-1:0] rsp_count;
   rsp_type        rsp_in, rsp_head;
   logic           read_room;

   assign stage_write = stage_valid_ff && (stage_op_ff == OP_WRITE);
   assign stage_read  = stage_valid_ff && (stage_op_ff == OP_READ);

   // The byte written on the previous cycle has not reached the read data yet.
   assign cur_byte = (fwd_valid_ff && (fwd_addr_ff == stage_addr_ff)) ? fwd_data_ff
                                                                      : ram_rd_data;
   assign bit_mask    = MSB_MASK >> stage_bit_ff;
   assign merged_byte = stage_set_ff ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);

   assign rsp_pop   = rsp_valid && rsp_ready;
   assign read_room = (3'(rsp_count) + 3'(stage_read))
                    < (3'(RSP_QUEUE_DEPTH) + 3'(rsp_pop));

   always_comb begin
      cmd_pop       = 1'b0;
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd_valid) begin
               case (cmd_head.op)
                  OP_CLEAR: begin
                     if (!stage_valid_ff) begin
                        cmd_pop       = 1'b1;
                        state_in      = ST_CLEAR;
                        clear_addr_in = '0;
                     end
                  end
                  OP_WRITE: cmd_pop = 1'b1;
                  OP_READ:  cmd_pop = read_room;
                  default:  cmd_pop = 1'b1;
               endcase
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_addr_ff;
         ram_wr_data = WHITE_BYTE;
      end else begin
         ram_wr_en   = stage_write;
         ram_wr_addr = stage_addr_ff;
         ram_wr_data = merged_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clear_addr_ff  <= '0;
         stage_valid_ff <= 1'b0;
         fwd_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_addr_ff  <= clear_addr_in;
         stage_valid_ff <= cmd_pop && (cmd_head.op != OP_CLEAR);
         fwd_valid_ff   <= stage_write;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         stage_op_ff   <= cmd_head.op;
         stage_addr_ff <= cmd_head.addr[AW-1:0];
         stage_bit_ff  <= cmd_head.bit_sel;
         stage_set_ff  <= cmd_head.set_bit;
         stage_last_ff <= cmd_head.last;
      end
      fwd_addr_ff <= stage_addr_ff;
      fwd_data_ff <= merged_byte;
   end

   rfb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cmd_head.addr[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_push           = stage_read;
   assign rsp_in.packed_byte = cur_byte;
   assign rsp_in.last_byte   = stage_last_ff;

   rfb_queue #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .pop       (rsp_pop),
      .head_data (rsp_head),
      .not_empty (rsp_not_empty),
      .full      (rsp_full),
      .count     (rsp_count)
   );

   assign rsp_valid       = rsp_not_empty && !(rsp_full && 1'b0);
   assign rsp_packed_byte = rsp_head.packed_byte;
   assign rsp_last_byte   = rsp_head.last_byte;

endmodule

// ===== sv/rgb565_to_mono_framebuffer_core.sv =====
// Top level of the RGB565 to one-bit panel frame store core.
//
// The req channel carries one word per action: start a frame, write one
// RGB565 pixel, or read the next byte of the frame store. Pixels arrive in
// raster order; the core tracks column and row itself, converts each pixel
// to gray, thresholds it and sets or clears one bit of the packed store.
// A read word returns one rsp word holding the stored byte and a flag on
// the final byte of the store; no other action produces an rsp word.
// The csr port writes image width, image height, orientation and the dark
// threshold; the user must use it only while the core is idle: not enforced.
// A front stage classifies each word combinationally and hands store
// commands to a four-entry queue; the back stage issues one command per
// cycle to the frame store RAM unless a sweep or full rsp queue holds it,
// with a read-modify-write of one bit. Without such holds, pixels and reads
// sustain one word per cycle; reads pass the stage register and rsp queue.
// After reset and after every start word the back stage sweeps the store
// to white, one byte per cycle over all STORE_BYTES bytes (4000 by default);
// words queue up until the sweep ends, and req_ready drops if the queue fills.
// When the rsp side stalls, two read results are held and further reads
// wait in the queue, and req_ready drops once that queue is full.
`timescale 1ns / 1ps
module rgb565_to_mono_framebuffer_core #(
   parameter int PANEL_WIDTH  = 250,
   parameter int PANEL_HEIGHT = 122,
   parameter int ROW_BYTES    = 16,
   parameter int STORE_BYTES  = 4000
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [rfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rfb_pkg::CFG_WIDTH-1:0]   csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [4:0]                      req_red,
   input  logic [5:0]                      req_green,
   input  logic [4:0]                      req_blue,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_packed_byte,
   output logic                            rsp_last_byte
);
   import rfb_pkg::*;

   localparam int CQW = $clog2(CMD_QUEUE_DEPTH + 1);

   logic           cmd_push, cmd_pop, cmd_valid, cmd_full;
   cmd_type        cmd_in, cmd_head;
   logic [CQW-1:0] cmd_count;

   rfb_front #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT),
      .ROW_BYTES    (ROW_BYTES),
      .STORE_BYTES  (STORE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .cmd_push   (cmd_push),
      .cmd_data   (cmd_in),
      .cmd_full   (cmd_full)
   );

   rfb_queue #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .head_data (cmd_head),
      .not_empty (cmd_valid),
      .full      (cmd_full),
      .count     (cmd_count)
   );

   rfb_back #(
      .STORE_BYTES (STORE_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_head        (cmd_head),
      .cmd_valid       (cmd_valid && (cmd_count != '0)),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule
